@@ hw/rtl/hmct_pkg.sv @@
// ----------------------------------------------------------------------------
// hmct_pkg: shared types and constants for the max-heap count tracker
// Entry layout, request/response payloads and status codes.
// ----------------------------------------------------------------------------
package hmct_pkg;

	localparam int CAPACITY   = 128;
	localparam int KEY_BITS   = 16;
	localparam int COUNT_BITS = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int OCC_W      = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [OCC_W-1:0]      occ_t;

	typedef enum logic [1:0] {
		STATUS_UPDATED  = 2'd0,
		STATUS_INSERTED = 2'd1,
		STATUS_DROPPED  = 2'd2
	} status_t;

	typedef struct packed {
		key_t   key;
		count_t count;
	} entry_t;

	typedef struct packed {
		logic [15:0] item_key;
		logic [15:0] add_count;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] top_key;
		logic [31:0] top_count;
		logic [7:0]  occupancy;
	} rsp_t;

endpackage

@@ hw/rtl/hmct_ram.sv @@
// ----------------------------------------------------------------------------
// hmct_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hmct_ram #(
	parameter  int WIDTH = 48,
	parameter  int DEPTH = 128,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/max_heap_count_tracker.sv @@
// ----------------------------------------------------------------------------
// max_heap_count_tracker: find-or-insert counter kept as a binary max-heap
// A request scans N entries (hit position, or occupancy on a miss), one RAM read per
//   cycle, then makes at most 7 parent compares on the way up to the root.
// One request in flight: the next is taken in the cycle after the response is
//   registered, and a stalled output holds the tracker in DONE.
// Reset clears the sequencer, occupancy and root copy; the entry RAM is not
//   cleared, since only occupied positions are ever compared.
// ----------------------------------------------------------------------------
module max_heap_count_tracker
	import hmct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Sequencer:
	//   IDLE   - take a request, launch read of slot 0
	//   SEARCH - compare the entry read back against the key, one per cycle
	//   SIFT   - launch read of the parent (or finish at the root)
	//   CMP    - parent smaller: move parent down into the hole and climb
	//   WRITE  - drop the carried entry into the hole
	//   DONE   - hand the response to the output register
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SIFT,
		ST_CMP,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t  state_q;
	key_t    key_q;       // request key, reduced to KEY_BITS
	count_t  amount_q;    // request amount
	addr_t   idx_q;       // slot whose data returns this cycle during SEARCH
	occ_t    pos_q;       // 1-based heap position of the hole
	entry_t  cur_q;       // entry being carried up
	occ_t    total_q;     // occupied positions
	entry_t  top_q;       // copy of heap root
	status_t status_q;

	logic   rsp_valid_q;
	rsp_t   rsp_q;

	// RAM hookup
	logic   ram_we;
	addr_t  ram_waddr;
	entry_t ram_wdata;
	addr_t  ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata_raw;
	entry_t ram_rdata;

	hmct_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// Shared datapath: one compare against RAM data per cycle
	logic               key_hit;
	logic [COUNT_BITS:0] sum;
	count_t             sat_sum;
	logic               parent_less;
	logic               last_scan;
	addr_t              parent_slot;
	addr_t              hole_slot;
	logic               out_free;

	assign key_hit     = (ram_rdata.key == key_q);
	assign sum         = {1'b0, ram_rdata.count} + {1'b0, amount_q};
	assign sat_sum     = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	assign parent_less = (ram_rdata.count < cur_q.count);
	assign last_scan   = ((OCC_W'(idx_q) + OCC_W'(1)) == total_q);
	assign parent_slot = ADDR_W'((pos_q >> 1) - OCC_W'(1));
	assign hole_slot   = ADDR_W'(pos_q - OCC_W'(1));
	assign out_free    = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = hole_slot;
		ram_wdata = cur_q;
		unique case (state_q)
			ST_SEARCH: begin
				ram_raddr = idx_q + ADDR_W'(1);
			end
			ST_SIFT: begin
				ram_raddr = parent_slot;
			end
			ST_CMP: begin
				// parent moves down into the hole
				ram_we    = parent_less;
				ram_wdata = ram_rdata;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= STATUS_DROPPED;
			key_q       <= '0;
			amount_q    <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			rsp_q       <= '0;
		end else begin
			// DONE reloads the output register itself when it is free
			if (rsp_valid_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						key_q    <= KEY_BITS'(req.item_key);
						amount_q <= COUNT_BITS'(req.add_count);
						idx_q    <= '0;
						if (total_q == '0) begin
							// empty heap: insert at the root
							cur_q    <= '{key: KEY_BITS'(req.item_key),
							              count: COUNT_BITS'(req.add_count)};
							pos_q    <= OCC_W'(1);
							total_q  <= OCC_W'(1);
							status_q <= STATUS_INSERTED;
							state_q  <= ST_SIFT;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (key_hit) begin
						cur_q    <= '{key: key_q, count: sat_sum};
						pos_q    <= OCC_W'(idx_q) + OCC_W'(1);
						status_q <= STATUS_UPDATED;
						state_q  <= ST_SIFT;
					end else if (last_scan) begin
						if (total_q == OCC_W'(CAPACITY)) begin
							status_q <= STATUS_DROPPED;
							state_q  <= ST_DONE;
						end else begin
							cur_q    <= '{key: key_q, count: amount_q};
							pos_q    <= total_q + OCC_W'(1);
							total_q  <= total_q + OCC_W'(1);
							status_q <= STATUS_INSERTED;
							state_q  <= ST_SIFT;
						end
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				ST_SIFT: begin
					state_q <= (pos_q == OCC_W'(1)) ? ST_WRITE : ST_CMP;
				end
				ST_CMP: begin
					if (parent_less) begin
						pos_q   <= pos_q >> 1;
						state_q <= ST_SIFT;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (pos_q == OCC_W'(1)) begin
						top_q <= cur_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.status    <= status_q;
						rsp_q.top_key   <= 16'(top_q.key);
						rsp_q.top_count <= 32'(top_q.count);
						rsp_q.occupancy <= 8'(total_q);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/hmct_checker.sv @@
// ----------------------------------------------------------------------------
// hmct_checker: port-level checks for the max-heap count tracker
// Watches the request/response ports; bound to the top level below.
// ----------------------------------------------------------------------------
module hmct_checker
	import hmct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STATUS_UPDATED) || (rsp.status == STATUS_INSERTED)
			|| (rsp.status == STATUS_DROPPED))
		else $error("unknown status code");

	// drops only when the heap is full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_DROPPED) |-> rsp.occupancy == 8'(CAPACITY))
		else $error("drop with free room");

	// after any update or insert the heap is not empty
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STATUS_DROPPED) |-> rsp.occupancy != 8'd0)
		else $error("empty heap after update or insert");

endmodule

bind max_heap_count_tracker hmct_checker u_hmct_checker (.*);
